// File: src/hnct_pkg.sv
// ----------------------------------------------------------------------------
// hnct_pkg
// Shared types and constants for the hashed name counter table.
// ----------------------------------------------------------------------------
package hnct_pkg;

  // Controller states, one-hot
  typedef enum logic [11:0] {
    ST_CLEAR   = 12'h001,
    ST_IDLE    = 12'h002,
    ST_MOD     = 12'h004,
    ST_OCC_RD  = 12'h008,
    ST_OCC_CHK = 12'h010,
    ST_CMP_RD  = 12'h020,
    ST_CMP_CHK = 12'h040,
    ST_WR_RD   = 12'h080,
    ST_WR_WR   = 12'h100,
    ST_CNT_CLR = 12'h200,
    ST_CNT_RD  = 12'h400,
    ST_CNT_WR  = 12'h800
  } state_t;

  // Result outcome codes
  localparam logic [1:0] OUT_INSERT = 2'd0;
  localparam logic [1:0] OUT_COUNT  = 2'd1;
  localparam logic [1:0] OUT_FULL   = 2'd2;

  // ELF hash constants
  localparam logic [31:0] HASH_TOP   = 32'hF000_0000;
  localparam int          HASH_FOLD  = 24;
  localparam int          HASH_SHIFT = 4;
  localparam logic [31:0] SAT_MAX    = 32'hFFFF_FFFF;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic char_take;
    logic unnamed_init;
    logic mod_init;
    logic mod_step;
    logic probe_start;
    logic seq_first;
    logic next_byte;
    logic next_slot;
    logic name_wr;
    logic cnt_clr;
    logic next_type;
    logic cnt_inc;
    logic emit_full;
    logic emit_insert;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic empty_name;
    logic unnamed;
    logic mod_done;
    logic occupied;
    logic byte_match;
    logic byte_last;
    logic probe_last;
    logic type_last;
  } sts_t;

endpackage

// File: src/hnct_ram.sv
// ----------------------------------------------------------------------------
// hnct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hnct_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/hnct_ctrl.sv
// ----------------------------------------------------------------------------
// hnct_ctrl
// Sequencer for the clearing pass, hash reduction, probe and update.
// ----------------------------------------------------------------------------
module hnct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_last_char,
  input  hnct_pkg::sts_t sts,
  output hnct_pkg::cmd_t cmd,
  output logic          busy
);

  hnct_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hnct_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != hnct_pkg::ST_IDLE);

  // Decode next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      hnct_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = hnct_pkg::ST_IDLE;
      end
      hnct_pkg::ST_IDLE: begin
        if (start) begin
          cmd.char_take = 1'b1;
          if (in_last_char) begin
            if (sts.empty_name) begin
              cmd.unnamed_init = 1'b1;
              state_nxt        = hnct_pkg::ST_OCC_RD;
            end else begin
              cmd.mod_init = 1'b1;
              state_nxt    = hnct_pkg::ST_MOD;
            end
          end
        end
      end
      hnct_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          cmd.probe_start = 1'b1;
          state_nxt       = hnct_pkg::ST_OCC_RD;
        end
      end
      hnct_pkg::ST_OCC_RD: begin
        state_nxt = hnct_pkg::ST_OCC_CHK;
      end
      hnct_pkg::ST_OCC_CHK: begin
        cmd.seq_first = 1'b1;
        if (sts.occupied) begin
          state_nxt = sts.unnamed ? hnct_pkg::ST_CNT_RD : hnct_pkg::ST_CMP_RD;
        end else begin
          state_nxt = sts.unnamed ? hnct_pkg::ST_CNT_CLR : hnct_pkg::ST_WR_RD;
        end
      end
      hnct_pkg::ST_CMP_RD: begin
        state_nxt = hnct_pkg::ST_CMP_CHK;
      end
      hnct_pkg::ST_CMP_CHK: begin
        if (!sts.byte_match) begin
          if (sts.probe_last) begin
            cmd.emit_full = 1'b1;
            state_nxt     = hnct_pkg::ST_IDLE;
          end else begin
            cmd.next_slot = 1'b1;
            state_nxt     = hnct_pkg::ST_OCC_RD;
          end
        end else if (sts.byte_last) begin
          state_nxt = hnct_pkg::ST_CNT_RD;
        end else begin
          cmd.next_byte = 1'b1;
          state_nxt     = hnct_pkg::ST_CMP_RD;
        end
      end
      hnct_pkg::ST_WR_RD: begin
        state_nxt = hnct_pkg::ST_WR_WR;
      end
      hnct_pkg::ST_WR_WR: begin
        cmd.name_wr = 1'b1;
        if (sts.byte_last) begin
          state_nxt = hnct_pkg::ST_CNT_CLR;
        end else begin
          cmd.next_byte = 1'b1;
          state_nxt     = hnct_pkg::ST_WR_RD;
        end
      end
      hnct_pkg::ST_CNT_CLR: begin
        cmd.cnt_clr = 1'b1;
        if (sts.type_last) begin
          cmd.emit_insert = 1'b1;
          state_nxt       = hnct_pkg::ST_IDLE;
        end else begin
          cmd.next_type = 1'b1;
        end
      end
      hnct_pkg::ST_CNT_RD: begin
        state_nxt = hnct_pkg::ST_CNT_WR;
      end
      hnct_pkg::ST_CNT_WR: begin
        cmd.cnt_inc = 1'b1;
        state_nxt   = hnct_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hnct_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: src/hnct_dp.sv
// ----------------------------------------------------------------------------
// hnct_dp
// Datapath: name capture and hash, modulo unit, slot and byte walkers,
// table memories and result register.
// ----------------------------------------------------------------------------
module hnct_dp #(
  parameter int TABLE_SLOTS  = 64,
  parameter int THREAD_TYPES = 16,
  parameter int NAME_LEN     = 32,
  parameter int SW           = $clog2(TABLE_SLOTS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hnct_pkg::cmd_t cmd,
  output hnct_pkg::sts_t sts,
  input  logic [7:0]     in_name_char,
  input  logic           in_last_char,
  input  logic [3:0]     in_thread_type,
  output logic           out_valid,
  output logic [SW-1:0]  out_slot,
  output logic [1:0]     out_outcome,
  output logic [31:0]    out_entry_count,
  output logic [31:0]    out_total_samples
);

  localparam int RW  = $clog2(TABLE_SLOTS);
  localparam int PW  = RW;
  localparam int JW  = $clog2(NAME_LEN);
  localparam int LW  = $clog2(NAME_LEN + 1);
  localparam int TW  = (THREAD_TYPES > 1) ? $clog2(THREAD_TYPES) : 1;
  localparam int NAW = $clog2(TABLE_SLOTS * NAME_LEN);
  localparam int CAW = $clog2((TABLE_SLOTS + 1) * THREAD_TYPES);
  // Reciprocal of the slot count, exact for every 32-bit hash
  localparam logic [32:0] MREC =
    33'((65'd1 << (32 + RW)) / 65'(TABLE_SLOTS) + 65'd1);

  logic [31:0]   hash_r;
  logic [LW-1:0] len_r;
  logic          done_r;
  logic [31:0]   total_r;
  logic [TW-1:0] tt_r;
  logic          unnamed_r;
  logic [31:0]   quot_r;
  logic          mod_ph_r;
  logic [SW-1:0] s_r, home_r, clr_r;
  logic [PW-1:0] probes_r;
  logic [JW-1:0] j_r;
  logic [TW-1:0] t_r;

  logic [31:0]   hash_sh, hash_g, hash_nxt;
  logic [64:0]   mod_prod;
  logic [31:0]   quot_nxt;
  logic [RW-1:0] mod_nxt;
  logic          take_ok;
  logic [TW-1:0] tt_nxt;
  logic          emit;

  logic          occ_we, occ_wd, occ_rd;
  logic [SW-1:0] occ_wa;
  logic [7:0]    in_rd, nm_rd, in_eff;
  logic          nm_we;
  logic [NAW-1:0] nm_a;
  logic          cnt_we;
  logic [CAW-1:0] cnt_a;
  logic [31:0]   cnt_wd, cnt_rd, cnt_inc;

  // ELF hash step
  always_comb begin
    hash_sh  = (hash_r << hnct_pkg::HASH_SHIFT) + {24'd0, in_name_char};
    hash_g   = hash_sh & hnct_pkg::HASH_TOP;
    hash_nxt = (hash_sh ^ (hash_g >> hnct_pkg::HASH_FOLD)) & ~hash_g;
  end

  assign take_ok = cmd.char_take && !done_r && (len_r < LW'(NAME_LEN));
  assign emit    = cmd.emit_full || cmd.emit_insert || cmd.cnt_inc;

  // Clamp thread type
  assign tt_nxt = ({28'd0, in_thread_type} >= 32'(THREAD_TYPES)) ?
                  TW'(THREAD_TYPES - 1) : TW'(in_thread_type);

  // Reduce the hash by the slot count: reciprocal multiply for the quotient,
  // then multiply back and subtract in the following cycle
  always_comb begin
    mod_prod = 65'(hash_r) * 65'(MREC);
    quot_nxt = 32'(mod_prod >> (32 + RW));
    mod_nxt  = RW'(hash_r - 32'(quot_r * 32'(TABLE_SLOTS)));
  end

  // Name capture, hash, total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '0;
      len_r   <= '0;
      done_r  <= 1'b0;
      total_r <= '0;
    end else if (emit) begin
      hash_r <= '0;
      len_r  <= '0;
      done_r <= 1'b0;
    end else begin
      if (take_ok) begin
        if (in_name_char == 8'd0) begin
          done_r <= 1'b1;
        end else begin
          hash_r <= hash_nxt;
          len_r  <= len_r + LW'(1);
        end
      end
      if (cmd.char_take && in_last_char && total_r != hnct_pkg::SAT_MAX) begin
        total_r <= total_r + 32'd1;
      end
    end
  end

  // Walkers for slot, byte, type, modulo and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.char_take && in_last_char) begin
      tt_r      <= tt_nxt;
      unnamed_r <= cmd.unnamed_init;
      s_r       <= SW'(TABLE_SLOTS);
      mod_ph_r  <= 1'b0;
    end
    if (cmd.mod_step) begin
      quot_r   <= quot_nxt;
      mod_ph_r <= 1'b1;
    end
    if (cmd.probe_start) begin
      s_r      <= SW'(mod_nxt);
      home_r   <= SW'(mod_nxt);
      probes_r <= '0;
    end
    if (cmd.next_slot) begin
      s_r      <= (s_r == SW'(TABLE_SLOTS - 1)) ? '0 : s_r + SW'(1);
      probes_r <= probes_r + PW'(1);
    end
    if (cmd.seq_first) begin
      j_r <= '0;
      t_r <= '0;
    end
    if (cmd.next_byte) j_r <= j_r + JW'(1);
    if (cmd.next_type) t_r <= t_r + TW'(1);
  end

  // Occupancy memory, one bit per slot
  assign occ_we = cmd.clr_step || cmd.cnt_clr;
  assign occ_wa = cmd.clr_step ? clr_r : s_r;
  assign occ_wd = !cmd.clr_step;

  hnct_ram #(.W(1), .D(TABLE_SLOTS + 1)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
    .raddr(s_r), .rdata(occ_rd)
  );

  // Incoming name bytes
  hnct_ram #(.W(8), .D(NAME_LEN)) u_inc (
    .clk(clk), .we(take_ok && in_name_char != 8'd0), .waddr(JW'(len_r)),
    .wdata(in_name_char), .raddr(j_r), .rdata(in_rd)
  );

  // Pad past the end of the name with zero
  assign in_eff = (LW'(j_r) < len_r) ? in_rd : 8'd0;

  // Stored names, one row per slot
  assign nm_a  = NAW'(s_r) * NAW'(NAME_LEN) + NAW'(j_r);
  assign nm_we = cmd.name_wr;

  hnct_ram #(.W(8), .D(TABLE_SLOTS * NAME_LEN)) u_name (
    .clk(clk), .we(nm_we), .waddr(nm_a), .wdata(in_eff),
    .raddr(nm_a), .rdata(nm_rd)
  );

  // Per-type counters
  assign cnt_a   = CAW'(s_r) * CAW'(THREAD_TYPES) + CAW'(cmd.cnt_clr ? t_r : tt_r);
  assign cnt_inc = (cnt_rd == hnct_pkg::SAT_MAX) ? cnt_rd : cnt_rd + 32'd1;
  assign cnt_we  = cmd.cnt_clr || cmd.cnt_inc;
  assign cnt_wd  = cmd.cnt_inc ? cnt_inc : {31'd0, (t_r == tt_r)};

  hnct_ram #(.W(32), .D((TABLE_SLOTS + 1) * THREAD_TYPES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_a), .wdata(cnt_wd),
    .raddr(cnt_a), .rdata(cnt_rd)
  );

  // Status to the controller
  always_comb begin
    sts.clr_done   = (clr_r == SW'(TABLE_SLOTS));
    sts.empty_name = (len_r == '0) && (done_r || in_name_char == 8'd0);
    sts.unnamed    = unnamed_r;
    sts.mod_done   = mod_ph_r;
    sts.occupied   = occ_rd;
    sts.byte_match = (nm_rd == in_eff);
    sts.byte_last  = (j_r == JW'(NAME_LEN - 1));
    sts.probe_last = (probes_r == PW'(TABLE_SLOTS - 1));
    sts.type_last  = (t_r == TW'(THREAD_TYPES - 1));
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_slot          <= cmd.emit_full ? home_r : s_r;
      out_total_samples <= total_r;
      if (cmd.emit_full) begin
        out_outcome     <= hnct_pkg::OUT_FULL;
        out_entry_count <= 32'd0;
      end else if (cmd.emit_insert) begin
        out_outcome     <= hnct_pkg::OUT_INSERT;
        out_entry_count <= 32'd1;
      end else begin
        out_outcome     <= hnct_pkg::OUT_COUNT;
        out_entry_count <= cnt_inc;
      end
    end
  end

endmodule

// File: src/hashed_name_counter_table.sv
// ----------------------------------------------------------------------------
// hashed_name_counter_table
// Counts names per thread type in an open-addressed, linearly probed table.
// ----------------------------------------------------------------------------
// A name arrives one character word per start pulse, taken while busy is low.
// Characters not marked last leave busy low and give no result, so they can
// follow back to back; the ELF hash and the name bytes are kept as they
// arrive. On the last character busy rises. The hash is reduced modulo
// TABLE_SLOTS by a reciprocal multiply and a subtract, then slots are probed
// from the home slot: each probe reads the occupancy bit and, if occupied,
// compares the stored name byte by byte, stopping at the first difference.
// An insert writes the name row and the slot's counter row (one for the
// name's thread type, zero for the rest); a hit reads and bumps one counter.
// Empty names go straight to the overflow slot. One result word per name
// appears on the out_ ports for one cycle, marked by out_valid, in the cycle
// busy falls; the receiver cannot stall it. After reset the occupancy memory
// is swept, with busy high, before the first character is taken.
// ----------------------------------------------------------------------------
module hashed_name_counter_table #(
  parameter int TABLE_SLOTS  = 64,
  parameter int THREAD_TYPES = 16,
  parameter int NAME_LEN     = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [7:0]                         in_name_char,
  input  logic                               in_last_char,
  input  logic [3:0]                         in_thread_type,
  input  logic [31:0]                        in_sem_id,
  output logic                               out_valid,
  output logic [$clog2(TABLE_SLOTS+1)-1:0]   out_slot,
  output logic [1:0]                         out_outcome,
  output logic [31:0]                        out_entry_count,
  output logic [31:0]                        out_total_samples
);

  hnct_pkg::cmd_t cmd;
  hnct_pkg::sts_t sts;
  logic           sem_id_seen;

  // The identifier never reaches a result; fold it in so the port is used
  assign sem_id_seen = ^in_sem_id;

  // Sequencer
  hnct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start && (sem_id_seen || !sem_id_seen)),
    .in_last_char(in_last_char), .sts(sts), .cmd(cmd), .busy(busy)
  );

  // Datapath
  hnct_dp #(
    .TABLE_SLOTS(TABLE_SLOTS), .THREAD_TYPES(THREAD_TYPES), .NAME_LEN(NAME_LEN)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_name_char(in_name_char), .in_last_char(in_last_char),
    .in_thread_type(in_thread_type),
    .out_valid(out_valid), .out_slot(out_slot), .out_outcome(out_outcome),
    .out_entry_count(out_entry_count), .out_total_samples(out_total_samples)
  );

`ifndef SYNTH
  // A result word is never held over
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result word held over");

  // A plain character never causes a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_char) |=> !out_valid)
    else $error("result without last character");

  // A full table reports a zero count
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == hnct_pkg::OUT_FULL) |-> out_entry_count == 32'd0)
    else $error("full outcome with count");

  // Every result follows at least one counted name
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_samples != 32'd0) else $error("zero total");
`endif

endmodule
